[sv/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg: shared types for the strongly connected components block
// Word formats, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int VC_W             = 7;
  localparam logic [VC_W-1:0] VERTEX_COUNT_RST = 7'd64;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
  } req_t;

  typedef struct packed {
    logic [63:0] member_mask;
    logic [5:0]  component_index;
    logic        dropped_flag;
    logic        last_component;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_F_INIT,
    S_F_NEXT,
    S_W_SCAN,
    S_W_EVAL,
    S_W_POP,
    S_R_INIT,
    S_R_NEXT,
    S_R_POPF,
    S_R_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept_edge;
    logic run_init;
    logic v_inc;
    logic start_fwd;
    logic scan_read;
    logic eval;
    logic finish_u;
    logic pop_load;
    logic rev_init;
    logic fin_read;
    logic start_rev;
    logic emit;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic v_done;
    logic v_visited;
    logic scan_end;
    logic depth_one;
    logic fdepth_zero;
    logic fin_visited;
    logic pend_valid;
    logic out_free;
    logic rev;
  } stat_t;

endpackage

[sv/strongly_connected_components_top.sv]
// ----------------------------------------------------------------------------
// strongly_connected_components_top: Kosaraju component search over a loaded graph
// Edge words fill an edge store; a run word emits every component as a mask.
// ----------------------------------------------------------------------------
// Throughput: edge words are taken back to back while no run is in progress.
// The running time of a run word is set by the single edge store read port: each pass scans
// every edge once per vertex, through a scan read state and an evaluate state for each edge.
// Components leave through one output register, so a stalled output slows a run.
// Reset (synchronous, active high) empties the edge store, clears the drop marker
// and sets vertex_count to 64; stored contents need no clearing pass.
module strongly_connected_components_top #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [scc_pkg::VC_W-1:0] cfg_wdata,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  scc_pkg::req_t            req,
  output logic                     res_valid,
  input  logic                     res_stall,
  output scc_pkg::res_t            res
);
  import scc_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  cmd_t  cmd;
  stat_t st;
  logic  busy;
  logic  req_fire;

  // The block takes a word only while no run is in progress.
  assign req_stall = busy;
  assign req_fire  = req_valid && !busy;

  scc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_fire   (req_fire),
    .req_is_run (req.req_type == REQ_RUN),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy)
  );

  scc_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[sv/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl: run sequencer
// Steps both depth-first passes and the component hand-off through the datapath.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_fire,
  input  logic           req_is_run,
  input  scc_pkg::stat_t st,
  output scc_pkg::cmd_t  cmd,
  output logic           busy
);
  import scc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_fire && req_is_run) state_next = S_F_INIT;
      S_F_INIT: state_next = S_F_NEXT;
      S_F_NEXT: begin
        if (st.v_done) state_next = S_R_INIT;
        else if (!st.v_visited) state_next = S_W_SCAN;
      end
      S_W_SCAN: begin
        if (!st.scan_end) state_next = S_W_EVAL;
        else if (!st.depth_one) state_next = S_W_POP;
        else if (st.rev) state_next = S_R_EMIT;
        else state_next = S_F_NEXT;
      end
      S_W_EVAL: state_next = S_W_SCAN;
      S_W_POP:  state_next = S_W_SCAN;
      S_R_INIT: state_next = S_R_NEXT;
      S_R_NEXT: state_next = st.fdepth_zero ? S_FINISH : S_R_POPF;
      S_R_POPF: state_next = st.fin_visited ? S_R_NEXT : S_W_SCAN;
      S_R_EMIT: if (!st.pend_valid || st.out_free) state_next = S_R_NEXT;
      S_FINISH: if (!st.pend_valid || st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy            = 1'b0;
        cmd.accept_edge = req_fire && !req_is_run;
      end
      S_F_INIT: cmd.run_init = 1'b1;
      S_F_NEXT: begin
        cmd.v_inc     = !st.v_done && st.v_visited;
        cmd.start_fwd = !st.v_done && !st.v_visited;
      end
      S_W_SCAN: begin
        cmd.scan_read = !st.scan_end;
        cmd.finish_u  = st.scan_end;
      end
      S_W_EVAL: cmd.eval = 1'b1;
      S_W_POP:  cmd.pop_load = 1'b1;
      S_R_INIT: cmd.rev_init = 1'b1;
      S_R_NEXT: cmd.fin_read = !st.fdepth_zero;
      S_R_POPF: cmd.start_rev = !st.fin_visited;
      S_R_EMIT: cmd.emit = !st.pend_valid || st.out_free;
      S_FINISH: cmd.final_emit = !st.pend_valid || st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

[sv/scc_dpath.sv]
// ----------------------------------------------------------------------------
// scc_dpath: edge store, walk stacks and component registers
// Executes the controller's commands; all memories have registered reads.
// ----------------------------------------------------------------------------
module scc_dpath #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [scc_pkg::VC_W-1:0] cfg_wdata,
  input  scc_pkg::req_t            req,
  input  scc_pkg::cmd_t            cmd,
  output scc_pkg::stat_t           st,
  output logic                     res_valid,
  input  logic                     res_stall,
  output scc_pkg::res_t            res
);
  import scc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = VW + 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [5:0]  esrc_mem [MAX_EDGES];
  logic [5:0]  etgt_mem [MAX_EDGES];
  logic [5:0]  wv_mem   [MAX_VERTICES];
  logic [EW-1:0] wp_mem [MAX_VERTICES];
  logic [5:0]  fin_mem  [MAX_VERTICES];

  logic [VC_W-1:0] vertex_count;
  logic [VC_W-1:0] n;
  logic [EW-1:0]   edge_count;
  logic            dropped;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] reached;
  logic [VC_W-1:0] v;
  logic            rev;
  logic [5:0]      cur_u;
  logic [EW-1:0]   cur_p;
  logic [DW-1:0]   depth;
  logic [DW-1:0]   fdepth;
  logic [5:0]      ea, eb, rd_a, rd_b;
  logic [5:0]      pop_v;
  logic [EW-1:0]   pop_p;
  logic [5:0]      fin_rd;
  logic            pend_valid;
  logic [MAX_VERTICES-1:0] pend_mask;
  logic [5:0]      pend_idx;
  logic [VC_W-1:0] comp_count;
  logic            out_free;
  logic            hit;
  logic [5:0]      start_vx;
  logic [DW-1:0]   depth_m1, depth_m2, fdepth_m1;

  assign n = (vertex_count > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vertex_count;
  assign out_free = !res_valid || !res_stall;
  assign ea = rev ? rd_b : rd_a;
  assign eb = rev ? rd_a : rd_b;
  assign hit = (ea == cur_u) && ({1'b0, ea} < n) && ({1'b0, eb} < n) && !visited[eb[VW-1:0]];
  assign start_vx = cmd.start_rev ? fin_rd : v[5:0];
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign fdepth_m1 = fdepth - DW'(1);

  always_comb begin
    st.v_done      = (v >= n);
    st.v_visited   = visited[v[VW-1:0]];
    st.scan_end    = (cur_p >= edge_count);
    st.depth_one   = (depth == DW'(1));
    st.fdepth_zero = (fdepth == '0);
    st.fin_visited = visited[fin_rd[VW-1:0]];
    st.pend_valid  = pend_valid;
    st.out_free    = out_free;
    st.rev         = rev;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_edge && !(edge_count >= EW'(MAX_EDGES)) &&
        ({1'b0, req.edge_from} < n) && ({1'b0, req.edge_to} < n)) begin
      esrc_mem[edge_count[AW-1:0]] <= req.edge_from;
      etgt_mem[edge_count[AW-1:0]] <= req.edge_to;
    end
    if (cmd.scan_read) begin
      rd_a <= esrc_mem[cur_p[AW-1:0]];
      rd_b <= etgt_mem[cur_p[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && hit) begin
      wv_mem[depth_m1[VW-1:0]] <= cur_u;
      wp_mem[depth_m1[VW-1:0]] <= cur_p + EW'(1);
    end
    if (cmd.finish_u && depth > DW'(1)) begin
      pop_v <= wv_mem[depth_m2[VW-1:0]];
      pop_p <= wp_mem[depth_m2[VW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_u && !rev) begin
      fin_mem[fdepth[VW-1:0]] <= cur_u;
    end
    if (cmd.fin_read) begin
      fin_rd <= fin_mem[fdepth_m1[VW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
      edge_count   <= '0;
      dropped      <= 1'b0;
      visited      <= '0;
      fdepth       <= '0;
      depth        <= '0;
      rev          <= 1'b0;
      pend_valid   <= 1'b0;
      res_valid    <= 1'b0;
      v            <= '0;
      comp_count   <= '0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (res_valid && !res_stall) res_valid <= 1'b0;

      if (cmd.accept_edge) begin
        if (edge_count >= EW'(MAX_EDGES) || ({1'b0, req.edge_from} >= n) ||
            ({1'b0, req.edge_to} >= n)) begin
          dropped <= 1'b1;
        end else begin
          edge_count <= edge_count + EW'(1);
        end
      end
      if (cmd.run_init) begin
        visited    <= '0;
        fdepth     <= '0;
        v          <= '0;
        rev        <= 1'b0;
        comp_count <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.v_inc) v <= v + VC_W'(1);
      if (cmd.start_fwd || cmd.start_rev) begin
        visited[start_vx[VW-1:0]] <= 1'b1;
        reached <= '0;
        reached[start_vx[VW-1:0]] <= 1'b1;
        cur_u <= start_vx;
        cur_p <= '0;
        depth <= DW'(1);
      end
      if (cmd.eval) begin
        if (hit) begin
          visited[eb[VW-1:0]] <= 1'b1;
          reached[eb[VW-1:0]] <= 1'b1;
          cur_u <= eb;
          cur_p <= '0;
          depth <= depth + DW'(1);
        end else begin
          cur_p <= cur_p + EW'(1);
        end
      end
      if (cmd.finish_u) begin
        depth <= depth_m1;
        if (!rev) fdepth <= fdepth + DW'(1);
      end
      if (cmd.pop_load) begin
        cur_u <= pop_v;
        cur_p <= pop_p;
      end
      if (cmd.rev_init) begin
        visited <= '0;
        rev     <= 1'b1;
      end
      if (cmd.fin_read) fdepth <= fdepth_m1;
      if (cmd.emit) begin
        if (pend_valid) begin
          res_valid           <= 1'b1;
          res.member_mask     <= 64'(pend_mask);
          res.component_index <= pend_idx;
          res.dropped_flag    <= dropped;
          res.last_component  <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_mask  <= reached;
        pend_idx   <= comp_count[5:0];
        comp_count <= comp_count + VC_W'(1);
      end
      if (cmd.final_emit) begin
        if (pend_valid) begin
          res_valid           <= 1'b1;
          res.member_mask     <= 64'(pend_mask);
          res.component_index <= pend_idx;
          res.dropped_flag    <= dropped;
          res.last_component  <= 1'b1;
        end
        pend_valid <= 1'b0;
        edge_count <= '0;
        dropped    <= 1'b0;
        visited    <= '0;
      end
    end
  end

endmodule

[bench/tb_strongly_connected_components_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strongly_connected_components_top: self-checking bench for the SCC block
// Loads directed graphs edge by edge, runs the component search and checks
// every emitted component against a predictor kept inside this bench, with
// random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_strongly_connected_components_top;
  import scc_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam int NE = MAX_EDGES_DEF;
  // Settle time before a register write; covers a run that emits nothing.
  localparam int SETTLE = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [VC_W-1:0] cfg_wdata;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;

  strongly_connected_components_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Words waiting to be offered, and components the block still owes us.
  req_t word_queue[$];
  res_t component_queue[$];

  // Predictor state: a mirror of the graph held by the block.
  logic [5:0] graph_src[NE];
  logic [5:0] graph_dst[NE];
  int graph_edges;
  bit graph_dropped;
  int vertex_setting;
  logic [63:0] seen;
  logic [5:0] finish_stack[NV];
  int finish_top;
  logic [5:0] path_vertex[NV];
  int path_pos[NV];

  int errors;
  int runs_done;
  int edges_sent;
  int components_checked;
  bit calm;
  bit hold_request;
  int hold_count;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  // One depth-first walk from root; the reverse walk follows edges backwards.
  // Returns the set of vertices it newly reached.
  function automatic logic [63:0] dfs_reach(int root, int n, bit reverse);
    logic [63:0] reached;
    int depth, top, u, p, a, b;
    bit pushed;
    reached = '0;
    seen[root] = 1'b1;
    reached[root] = 1'b1;
    path_vertex[0] = root[5:0];
    path_pos[0] = 0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      u = int'(path_vertex[top]);
      p = path_pos[top];
      pushed = 0;
      while (p < graph_edges && !pushed) begin
        a = reverse ? int'(graph_dst[p]) : int'(graph_src[p]);
        b = reverse ? int'(graph_src[p]) : int'(graph_dst[p]);
        p++;
        if (a == u && a < n && b < n && !seen[b] && depth < NV) begin
          path_pos[top] = p;
          seen[b] = 1'b1;
          reached[b] = 1'b1;
          path_vertex[depth] = b[5:0];
          path_pos[depth] = 0;
          depth++;
          pushed = 1;
        end
      end
      if (!pushed) begin
        depth--;
        if (!reverse && finish_top < NV) begin
          finish_stack[finish_top] = u[5:0];
          finish_top++;
        end
      end
    end
    return reached;
  endfunction

  // Work out the effect of one accepted word: store an edge, or run the
  // two-pass search and queue the components it finds.
  function automatic void predict_word(req_t w);
    int n, v, count;
    res_t found[$];
    res_t item;
    n = (vertex_setting > NV) ? NV : vertex_setting;
    if (w.req_type == REQ_EDGE) begin
      if (graph_edges >= NE || w.edge_from >= n || w.edge_to >= n) begin
        graph_dropped = 1;
      end else begin
        graph_src[graph_edges] = w.edge_from;
        graph_dst[graph_edges] = w.edge_to;
        graph_edges++;
      end
      return;
    end
    seen = '0;
    finish_top = 0;
    for (v = 0; v < n; v++)
      if (!seen[v]) void'(dfs_reach(v, n, 0));
    seen = '0;
    count = 0;
    while (finish_top > 0) begin
      finish_top--;
      v = int'(finish_stack[finish_top]);
      if (!seen[v]) begin
        item.member_mask = dfs_reach(v, n, 1);
        item.component_index = count[5:0];
        item.dropped_flag = graph_dropped;
        item.last_component = 1'b0;
        found.insert(found.size(), item);
        count++;
      end
    end
    if (count > 0) found[count-1].last_component = 1'b1;
    foreach (found[i]) component_queue.insert(component_queue.size(), found[i]);
    graph_edges = 0;
    graph_dropped = 0;
    runs_done++;
  endfunction

  // Sender: holds a word until it is taken, otherwise idles now and then.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_word(req);
        if (req.req_type == REQ_EDGE) edges_sent++;
      end
      if (req_valid && req_stall) begin
        req_valid <= 1'b1;
      end else if (word_queue.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        req_valid <= 1'b1;
        req <= word_queue.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_count <= 400;
      res_stall <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  // Monitor: every accepted component must match the oldest one expected.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (component_queue.size() == 0) begin
        report_mismatch("unexpected component", res.member_mask, 64'd0);
      end else begin
        res_t want;
        want = component_queue.pop_front();
        if (res.member_mask !== want.member_mask)
          report_mismatch("member_mask", res.member_mask, want.member_mask);
        if (res.component_index !== want.component_index)
          report_mismatch("component_index", 64'(res.component_index),
                          64'(want.component_index));
        if (res.dropped_flag !== want.dropped_flag)
          report_mismatch("dropped_flag", 64'(res.dropped_flag), 64'(want.dropped_flag));
        if (res.last_component !== want.last_component)
          report_mismatch("last_component", 64'(res.last_component),
                          64'(want.last_component));
        components_checked++;
      end
    end
  end

  task automatic add_edge(int from_v, int to_v);
    req_t w;
    w.req_type = REQ_EDGE;
    w.edge_from = from_v[5:0];
    w.edge_to = to_v[5:0];
    word_queue.insert(word_queue.size(), w);
  endtask

  task automatic add_run();
    req_t w;
    w.req_type = REQ_RUN;
    w.edge_from = 6'($urandom_range(0, 63));
    w.edge_to = 6'($urandom_range(0, 63));
    word_queue.insert(word_queue.size(), w);
  endtask

  // Wait until every word is taken and every component has come back, then
  // give a run that emits nothing time to finish.
  task automatic wait_idle();
    wait (word_queue.size() == 0);
    @(posedge clk);
    while (req_valid || component_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[VC_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_setting = value;
  endtask

  initial begin
    int n, k, pick, sent_target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req = '0;
    res_stall = 1'b0;
    hold_request = 0;
    calm = 0;
    errors = 0;
    runs_done = 0;
    edges_sent = 0;
    components_checked = 0;
    graph_edges = 0;
    graph_dropped = 0;
    vertex_setting = int'(VERTEX_COUNT_RST);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value of 64: extreme vertices forming one cycle, plus a lone edge.
    add_edge(0, 63);
    add_edge(63, 0);
    add_edge(63, 63);
    add_edge(5, 42);
    add_run();
    wait_idle();

    // A vertex beyond the count is dropped and flagged on every component.
    write_vertex_count(10);
    add_edge(12, 3);
    add_edge(3, 9);
    add_edge(9, 3);
    add_edge(2, 10);
    add_run();
    // The run clears the flag, so this one reports no drops.
    add_edge(1, 0);
    add_run();
    wait_idle();

    // Out-of-range register settings: zero vertices, and a value clamped to 64.
    write_vertex_count(0);
    add_edge(0, 0);
    add_run();
    wait_idle();
    write_vertex_count(127);
    add_edge(63, 62);
    add_edge(62, 63);
    add_run();
    wait_idle();

    // Edges loaded at full size, then the count lowered before the run.
    write_vertex_count(64);
    add_edge(40, 1);
    add_edge(1, 2);
    add_edge(2, 1);
    add_edge(3, 50);
    wait_idle();
    write_vertex_count(20);
    add_run();
    wait_idle();

    // Long receiver hold-off: 64 singleton components pile up while the
    // sender keeps offering the next graph, so the input has to stall.
    write_vertex_count(64);
    add_run();
    for (k = 0; k < 20; k++) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
    add_run();
    @(negedge clk);
    hold_request = 1;
    wait_idle();

    // Random graphs, each loaded with mostly in-range edges and then run.
    sent_target = edges_sent + 160;
    while (edges_sent < sent_target) begin
      calm = (runs_done % 7 == 3);
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 64;
      else if (pick == 1) n = 1;
      else if (pick < 6) n = $urandom_range(2, 8);
      else n = $urandom_range(2, 64);
      write_vertex_count(n);
      for (k = $urandom_range(0, 25); k > 0; k--) begin
        if ($urandom_range(0, 99) < 88)
          add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        else
          add_edge($urandom_range(0, 63), $urandom_range(0, 63));
      end
      add_run();
      wait_idle();
    end
    calm = 0;

    $display("covered %0d runs over %0d edge words, %0d components compared",
             runs_done, edges_sent, components_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
